// File: rtl/core/cvr_pkg.sv
package cvr_pkg;

  localparam int MAX_ITERATIONS = 16;
  localparam int SAMPLE_WIDTH   = 16;
  localparam int ANGLE_W        = 16;
  localparam int ITER_W         = $clog2(MAX_ITERATIONS);
  localparam int LAST_W         = 4;
  localparam int GAIN_W         = 15;
  localparam int CFG_DATA_W     = GAIN_W;
  localparam int CFG_IDX_W      = 1;
  // three guard bits above the sample range cover pre-rotation and cordic gain
  localparam int XY_W           = SAMPLE_WIDTH + 3;
  localparam int ACC_W          = ANGLE_W + 1;
  localparam int RES_W          = SAMPLE_WIDTH + 1;
  localparam int PROD_W         = XY_W + GAIN_W + 1;

  localparam int ANGLE_HALF_PI  = 12868;
  localparam int ANGLE_PI       = 25736;
  localparam int LAST_RESET     = 15;
  localparam int GAIN_RESET     = 19899;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAST_ITER = 1'b0,
    REG_GAIN      = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_VECTOR = 1'b0,
    OP_ROTATE = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e                   op;
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ANGLE_W-1:0] t;
  } cell_data_t;

  // atan(2^-i) in q3.13, rounded to nearest
  function automatic logic signed [ACC_W-1:0] atan_rom(logic [ITER_W-1:0] idx);
    logic signed [ACC_W-1:0] r;
    case (int'(idx))
      0:       r = ACC_W'(6434);
      1:       r = ACC_W'(3798);
      2:       r = ACC_W'(2007);
      3:       r = ACC_W'(1019);
      4:       r = ACC_W'(511);
      5:       r = ACC_W'(256);
      6:       r = ACC_W'(128);
      7:       r = ACC_W'(64);
      8:       r = ACC_W'(32);
      9:       r = ACC_W'(16);
      10:      r = ACC_W'(8);
      11:      r = ACC_W'(4);
      12:      r = ACC_W'(2);
      13:      r = ACC_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/cvr_in_if.sv
interface cvr_in_if;
  import cvr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic signed [SAMPLE_WIDTH-1:0] i_sample;
  logic signed [SAMPLE_WIDTH-1:0] q_sample;
  logic signed [ANGLE_W-1:0]      target_angle;

  modport source (output valid, opcode, i_sample, q_sample, target_angle, input ready);
  modport sink   (input valid, opcode, i_sample, q_sample, target_angle, output ready);
endinterface

// File: rtl/core/cvr_out_if.sv
interface cvr_out_if;
  import cvr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [RES_W-1:0]   x_result;
  logic signed [RES_W-1:0]   y_result;
  logic signed [ANGLE_W-1:0] phase_result;

  modport source (output valid, x_result, y_result, phase_result, input ready);
  modport sink   (input valid, x_result, y_result, phase_result, output ready);
endinterface

// File: rtl/core/cordic_vector_rotate_unit_top.sv
// circular cordic unit. opcode 0 (vectoring) returns the gain-corrected
// magnitude and the phase of (i_sample, q_sample); opcode 1 (rotation)
// returns the gain-corrected cosine and sine of target_angle. the datapath is
// a row of MAX_ITERATIONS micro-rotation cells behind a pre-rotation stage and
// followed by a two-stage gain multiply, so every request passes through the
// pre-rotation register, all cells and both gain stages whatever last_iteration
// holds (cells past the last index pass data through). one request can be taken
// per cycle; the whole row stalls while the output register holds an unclaimed result.
// write last_iteration and gain_correction only while the unit is empty.
module cordic_vector_rotate_unit_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  cvr_in_if.sink                             in_i,
  cvr_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [cvr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cvr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import cvr_pkg::*;

  logic [LAST_W-1:0] last_q;
  logic [GAIN_W-1:0] gain_q;
  logic [ITER_W-1:0] last_eff;
  logic              en;

  logic       valid_c [MAX_ITERATIONS+1];
  cell_data_t data_c  [MAX_ITERATIONS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= LAST_W'(LAST_RESET);
      gain_q <= GAIN_W'(GAIN_RESET);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LAST_ITER: last_q <= cfg_data_i[LAST_W-1:0];
        REG_GAIN:      gain_q <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign last_eff = (int'(last_q) > MAX_ITERATIONS - 1) ? ITER_W'(MAX_ITERATIONS - 1)
                                                        : ITER_W'(last_q);

  // whole chain advances unless a finished result is waiting
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  cvr_prerot u_prerot (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (in_i.valid),
    .opcode_i       (in_i.opcode),
    .i_sample_i     (in_i.i_sample),
    .q_sample_i     (in_i.q_sample),
    .target_angle_i (in_i.target_angle),
    .valid_o        (valid_c[0]),
    .data_o         (data_c[0])
  );

  for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_cell
    cvr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (ITER_W'(g)),
      .last_i  (last_eff),
      .valid_i (valid_c[g]),
      .data_i  (data_c[g]),
      .valid_o (valid_c[g+1]),
      .data_o  (data_c[g+1])
    );
  end

  cvr_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .gain_i  (gain_q),
    .valid_i (valid_c[MAX_ITERATIONS]),
    .data_i  (data_c[MAX_ITERATIONS]),
    .valid_o (out_o.valid),
    .x_o     (out_o.x_result),
    .y_o     (out_o.y_result),
    .phase_o (out_o.phase_result)
  );
endmodule

// File: rtl/core/cvr_prerot.sv
module cvr_prerot (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic                              opcode_i,
  input  logic signed [cvr_pkg::SAMPLE_WIDTH-1:0] i_sample_i,
  input  logic signed [cvr_pkg::SAMPLE_WIDTH-1:0] q_sample_i,
  input  logic signed [cvr_pkg::ANGLE_W-1:0]      target_angle_i,
  output logic                              valid_o,
  output cvr_pkg::cell_data_t               data_o
);
  import cvr_pkg::*;

  logic signed [XY_W-1:0]    a_ext, b_ext, one;
  logic signed [ANGLE_W-1:0] t_sat;
  cell_data_t                data_d, data_q;
  logic                      valid_q;

  always_comb begin
    a_ext = XY_W'(i_sample_i);
    b_ext = XY_W'(q_sample_i);
    one   = XY_W'(1) <<< (SAMPLE_WIDTH - 1);

    if (target_angle_i > ANGLE_W'(ANGLE_PI)) begin
      t_sat = ANGLE_W'(ANGLE_PI);
    end else if (target_angle_i < -ANGLE_W'(ANGLE_PI)) begin
      t_sat = -ANGLE_W'(ANGLE_PI);
    end else begin
      t_sat = target_angle_i;
    end

    data_d.op = opcode_e'(opcode_i);
    data_d.t  = t_sat;
    if (opcode_e'(opcode_i) == OP_VECTOR) begin
      // left half plane is turned by a quarter first
      if (a_ext < 0) begin
        if (b_ext > 0) begin
          data_d.x   = b_ext;
          data_d.y   = -a_ext;
          data_d.acc = -ACC_W'(ANGLE_HALF_PI);
        end else begin
          data_d.x   = -b_ext;
          data_d.y   = a_ext;
          data_d.acc = ACC_W'(ANGLE_HALF_PI);
        end
      end else begin
        data_d.x   = a_ext;
        data_d.y   = b_ext;
        data_d.acc = '0;
      end
    end else begin
      if (t_sat > ANGLE_W'(ANGLE_HALF_PI)) begin
        data_d.x   = '0;
        data_d.y   = one;
        data_d.acc = ACC_W'(ANGLE_HALF_PI);
      end else if (t_sat < -ANGLE_W'(ANGLE_HALF_PI)) begin
        data_d.x   = '0;
        data_d.y   = -one;
        data_d.acc = -ACC_W'(ANGLE_HALF_PI);
      end else begin
        data_d.x   = one;
        data_d.y   = '0;
        data_d.acc = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// File: rtl/core/cvr_cell.sv
module cvr_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [cvr_pkg::ITER_W-1:0]    idx_i,
  input  logic [cvr_pkg::ITER_W-1:0]    last_i,
  input  logic                          valid_i,
  input  cvr_pkg::cell_data_t           data_i,
  output logic                          valid_o,
  output cvr_pkg::cell_data_t           data_o
);
  import cvr_pkg::*;

  logic signed [XY_W-1:0]    xs, ys;
  logic signed [ACC_W:0]     err;
  logic signed [ACC_W-1:0]   step;
  logic                      neg;
  cell_data_t                data_d, data_q;
  logic                      valid_q;

  always_comb begin
    xs   = data_i.x >>> idx_i;
    ys   = data_i.y >>> idx_i;
    step = atan_rom(idx_i);
    err  = (ACC_W + 1)'(data_i.t) - (ACC_W + 1)'(data_i.acc);
    if (data_i.op == OP_VECTOR) begin
      neg = (data_i.y >= 0);
    end else begin
      neg = (err < 0);
    end

    data_d = data_i;
    // cells past the programmed last index pass the vector through
    if (idx_i <= last_i) begin
      if (neg) begin
        data_d.x   = data_i.x + ys;
        data_d.y   = data_i.y - xs;
        data_d.acc = data_i.acc - step;
      end else begin
        data_d.x   = data_i.x - ys;
        data_d.y   = data_i.y + xs;
        data_d.acc = data_i.acc + step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// File: rtl/core/cvr_scale.sv
module cvr_scale (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic [cvr_pkg::GAIN_W-1:0]           gain_i,
  input  logic                                 valid_i,
  input  cvr_pkg::cell_data_t                  data_i,
  output logic                                 valid_o,
  output logic signed [cvr_pkg::RES_W-1:0]     x_o,
  output logic signed [cvr_pkg::RES_W-1:0]     y_o,
  output logic signed [cvr_pkg::ANGLE_W-1:0]   phase_o
);
  import cvr_pkg::*;

  localparam int SUM_W = PROD_W + 1;

  function automatic logic signed [RES_W-1:0] round_sat(logic signed [PROD_W-1:0] p);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] hi;
    s  = (SUM_W'(p) + SUM_W'(16384)) >>> 15;
    hi = (SUM_W'(1) <<< (RES_W - 1)) - SUM_W'(1);
    if (s > hi) begin
      return RES_W'(hi);
    end else if (s < -hi - SUM_W'(1)) begin
      return RES_W'(-hi - SUM_W'(1));
    end
    return RES_W'(s);
  endfunction

  logic signed [GAIN_W:0]    gain_s;
  logic signed [PROD_W-1:0]  px_d, py_d, px_q, py_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W:0]     phase_neg;
  opcode_e                   op_q;
  logic                      mul_valid_q, out_valid_q;
  logic signed [RES_W-1:0]   x_q, y_q;
  logic signed [ANGLE_W-1:0] phase_q, phase_d;

  always_comb begin
    gain_s = $signed({1'b0, gain_i});
    px_d   = PROD_W'(data_i.x) * PROD_W'(gain_s);
    py_d   = PROD_W'(data_i.y) * PROD_W'(gain_s);

    phase_neg = -(ACC_W + 1)'(acc_q);
    if (phase_neg > (ACC_W + 1)'(ANGLE_PI)) begin
      phase_d = ANGLE_W'(ANGLE_PI);
    end else if (phase_neg < -(ACC_W + 1)'(ANGLE_PI)) begin
      phase_d = -ANGLE_W'(ANGLE_PI);
    end else begin
      phase_d = ANGLE_W'(phase_neg);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      mul_valid_q <= valid_i;
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= px_d;
      py_q  <= py_d;
      acc_q <= data_i.acc;
      op_q  <= data_i.op;
      x_q   <= round_sat(px_q);
      if (op_q == OP_VECTOR) begin
        y_q     <= '0;
        phase_q <= phase_d;
      end else begin
        y_q     <= round_sat(py_q);
        phase_q <= '0;
      end
    end
  end

  assign valid_o = out_valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign phase_o = phase_q;
endmodule

// File: verif/cordic_vector_rotate_unit_top_tb.sv
module cordic_vector_rotate_unit_top_tb;
  import cvr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 300;
  localparam longint SAMPLE_ONE = 32768;
  localparam longint RES_MAX = 65535;
  localparam longint RES_MIN = -65536;

  // atan(2^-k) in q3.13
  localparam int ATAN_Q13 [0:15] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                                     32, 16, 8, 4, 2, 1, 0, 0};

  typedef struct {
    logic signed [RES_W-1:0]   x;
    logic signed [RES_W-1:0]   y;
    logic signed [ANGLE_W-1:0] phase;
  } cordic_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  cvr_in_if  req_if ();
  cvr_out_if res_if ();

  cordic_vector_rotate_unit_top uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (req_if),
    .out_o     (res_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  logic [LAST_W-1:0] model_last_iter;
  logic [GAIN_W-1:0] model_gain;
  cordic_result_t    pending_results [$];
  int                mismatch_count;
  int                cycle_count;
  int                hold_request;
  bit                sender_idle;
  bit                receiver_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [RES_W-1:0] gain_scale(longint v);
    longint p;
    p = (v * longint'(model_gain) + 16384) >>> 15;
    p = clamp(p, RES_MIN, RES_MAX);
    return p[RES_W-1:0];
  endfunction

  function automatic cordic_result_t predict_cordic(opcode_e op, logic signed [15:0] i_s,
                                                    logic signed [15:0] q_s,
                                                    logic signed [15:0] ang);
    cordic_result_t r;
    longint x, y, acc, xo, t, p;
    int last, k;
    last = int'(model_last_iter);
    if (last > MAX_ITERATIONS - 1) last = MAX_ITERATIONS - 1;
    if (op == OP_VECTOR) begin
      // left half plane is folded over by a quarter turn first
      if (i_s < 0) begin
        if (q_s > 0) begin
          x = q_s;
          y = -longint'(i_s);
          acc = -ANGLE_HALF_PI;
        end else begin
          x = -longint'(q_s);
          y = i_s;
          acc = ANGLE_HALF_PI;
        end
      end else begin
        x = i_s;
        y = q_s;
        acc = 0;
      end
      for (k = 0; k <= last; k++) begin
        xo = x;
        if (y >= 0) begin
          x = x + (y >>> k);
          y = y - (xo >>> k);
          acc = acc - ATAN_Q13[k];
        end else begin
          x = x - (y >>> k);
          y = y + (xo >>> k);
          acc = acc + ATAN_Q13[k];
        end
      end
      r.x = gain_scale(x);
      r.y = '0;
      p = clamp(-acc, -ANGLE_PI, ANGLE_PI);
      r.phase = p[ANGLE_W-1:0];
    end else begin
      t = clamp(longint'(ang), -ANGLE_PI, ANGLE_PI);
      if (t > ANGLE_HALF_PI) begin
        x = 0;
        y = SAMPLE_ONE;
        acc = ANGLE_HALF_PI;
      end else if (t < -ANGLE_HALF_PI) begin
        x = 0;
        y = -SAMPLE_ONE;
        acc = -ANGLE_HALF_PI;
      end else begin
        x = SAMPLE_ONE;
        y = 0;
        acc = 0;
      end
      for (k = 0; k <= last; k++) begin
        xo = x;
        if (t - acc < 0) begin
          x = x + (y >>> k);
          y = y - (xo >>> k);
          acc = acc - ATAN_Q13[k];
        end else begin
          x = x - (y >>> k);
          y = y + (xo >>> k);
          acc = acc + ATAN_Q13[k];
        end
      end
      r.x = gain_scale(x);
      r.y = gain_scale(y);
      r.phase = '0;
    end
    return r;
  endfunction

  // valid is left high after acceptance so back-to-back requests need no gap
  task automatic send_request(opcode_e op, logic signed [15:0] i_s, logic signed [15:0] q_s,
                              logic signed [15:0] ang);
    int gap;
    gap = sender_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.i_sample     <= i_s;
    req_if.q_sample     <= q_s;
    req_if.target_angle <= ang;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(predict_cordic(op, i_s, q_s, ang));
  endtask

  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LAST_ITER) model_last_iter = data[LAST_W-1:0];
    else model_gain = data;
  endtask

  task automatic set_last_iteration(int n);
    logic [CFG_DATA_W-1:0] data;
    // upper bits carry junk, only the low nibble counts
    data = CFG_DATA_W'($urandom);
    data[LAST_W-1:0] = LAST_W'(n);
    write_register(REG_LAST_ITER, data);
  endtask

  function automatic logic signed [15:0] extreme_sample();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return 16'sh0001;
    endcase
  endfunction

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 511)) - 16'sd256;
      1:       return extreme_sample();
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] random_angle();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2 * ANGLE_PI) - ANGLE_PI);
  endfunction

  task automatic send_random_request();
    send_request(opcode_e'($urandom_range(0, 1)), random_sample(), random_sample(),
                 random_angle());
  endtask

  task automatic test_directed_cases();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    // vectoring: axis extremes, each pre-rotation branch, zero vector, phase clamp
    send_request(OP_VECTOR, 16'sh7fff, 16'sh0000, random_angle());
    send_request(OP_VECTOR, 16'sh8000, 16'sh0000, random_angle());
    send_request(OP_VECTOR, 16'sh0000, 16'sh7fff, random_angle());
    send_request(OP_VECTOR, 16'sh0000, 16'sh8000, random_angle());
    send_request(OP_VECTOR, 16'sh7fff, 16'sh7fff, random_angle());
    send_request(OP_VECTOR, 16'sh8000, 16'sh8000, random_angle());
    send_request(OP_VECTOR, 16'sh8000, 16'sh7fff, random_angle());
    send_request(OP_VECTOR, 16'sh7fff, 16'sh8000, random_angle());
    send_request(OP_VECTOR, 16'shffff, 16'sh0000, random_angle());
    send_request(OP_VECTOR, 16'shffff, 16'shffff, random_angle());
    send_request(OP_VECTOR, 16'shffff, 16'sh0001, random_angle());
    send_request(OP_VECTOR, 16'sh0000, 16'sh0000, random_angle());
    // rotation: start regions around +-pi/2, the pi limit and saturation past it
    send_request(OP_ROTATE, random_sample(), random_sample(), 16'sh0000);
    send_request(OP_ROTATE, random_sample(), random_sample(), 16'(ANGLE_HALF_PI));
    send_request(OP_ROTATE, random_sample(), random_sample(), 16'(ANGLE_HALF_PI + 1));
    send_request(OP_ROTATE, random_sample(), random_sample(), 16'(-ANGLE_HALF_PI));
    send_request(OP_ROTATE, random_sample(), random_sample(), 16'(-ANGLE_HALF_PI - 1));
    send_request(OP_ROTATE, random_sample(), random_sample(), 16'(ANGLE_PI));
    send_request(OP_ROTATE, random_sample(), random_sample(), 16'(-ANGLE_PI));
    send_request(OP_ROTATE, random_sample(), random_sample(), 16'(ANGLE_PI + 1));
    send_request(OP_ROTATE, random_sample(), random_sample(), 16'sh7fff);
    send_request(OP_ROTATE, random_sample(), random_sample(), 16'sh8000);
    wait_all_results();
  endtask

  task automatic test_output_stall();
    int n;
    sender_idle  = 1'b0;
    hold_request = 150;
    for (n = 0; n < 45; n++) send_random_request();
    wait_all_results();
  endtask

  task automatic run_random_phase(int last_iter, int gain, bit tx_idle, bit rx_idle);
    int n;
    set_last_iteration(last_iter);
    write_register(REG_GAIN, CFG_DATA_W'(gain));
    sender_idle   = tx_idle;
    receiver_idle = rx_idle;
    for (n = 0; n < ITEMS_PER_PHASE; n++) send_random_request();
    wait_all_results();
  endtask

  task automatic test_random_settings();
    run_random_phase(LAST_RESET, GAIN_RESET, 1'b1, 1'b1);
    run_random_phase(0, 32767, 1'b1, 1'b1);
    run_random_phase(15, 0, 1'b0, 1'b0);
    run_random_phase(15, 32767, 1'b1, 1'b0);
    run_random_phase($urandom_range(1, 14), $urandom_range(0, 32767), 1'b0, 1'b1);
    run_random_phase($urandom_range(0, 15), $urandom_range(16384, 32767), 1'b1, 1'b1);
  endtask

  initial begin : stimulus
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= REG_LAST_ITER;
    cfg_data            <= '0;
    req_if.valid        <= 1'b0;
    req_if.opcode       <= OP_VECTOR;
    req_if.i_sample     <= '0;
    req_if.q_sample     <= '0;
    req_if.target_angle <= '0;
    model_last_iter = LAST_W'(LAST_RESET);
    model_gain      = GAIN_W'(GAIN_RESET);
    mismatch_count  = 0;
    hold_request    = 0;
    sender_idle     = 1'b1;
    receiver_idle   = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_output_stall();
    test_random_settings();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS cordic_vector_rotate_unit_top");
    end else begin
      $display("FAIL cordic_vector_rotate_unit_top");
    end
    $finish;
  end

  initial begin : result_ready_driver
    int stall;
    res_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = receiver_idle ? $urandom_range(0, 12) : 0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready) && hold_request == 0);
    end
  end

  always @(posedge clk) begin : result_checker
    cordic_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result x %0d y %0d phase %0d", $time, res_if.x_result,
                 res_if.y_result, res_if.phase_result);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_if.x_result !== want.x) begin
          $display("%0t: x_result expected %0d got %0d", $time, want.x, res_if.x_result);
          mismatch_count++;
        end
        if (res_if.y_result !== want.y) begin
          $display("%0t: y_result expected %0d got %0d", $time, want.y, res_if.y_result);
          mismatch_count++;
        end
        if (res_if.phase_result !== want.phase) begin
          $display("%0t: phase_result expected %0d got %0d", $time, want.phase,
                   res_if.phase_result);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL cordic_vector_rotate_unit_top");
    $finish;
  end

endmodule
